/* hdl/pida_pkg.sv */
// Package with the shared types, codes and defaults of the positional insert/delete array.
`timescale 1ns / 1ps

package pida_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int WORD_WIDTH_DEF = 32;

    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_READ   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_BADPOS = 2'd1,
        ST_FULL   = 2'd2
    } status_t;

    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] value;
        logic        [4:0]  position;
    } request_t;

    typedef struct packed {
        logic signed [31:0] data_out;
        logic        [4:0]  used_count;
        status_t            status;
    } result_t;

    // Shift commands broadcast from the controller to every cell.
    typedef struct packed {
        logic       ins;
        logic       del;
        logic [4:0] position;
    } cell_ctrl_t;

endpackage

/* hdl/pida_cell.sv */
// One storage cell of the array: holds a word and shifts it to or from its neighbors.
`timescale 1ns / 1ps

module pida_cell #(
    parameter int WORD_WIDTH = pida_pkg::WORD_WIDTH_DEF,
    parameter int INDEX      = 0
) (
    input  logic                         clk,
    input  pida_pkg::cell_ctrl_t         ctrl,
    input  logic signed [WORD_WIDTH-1:0] ins_word,
    input  logic signed [WORD_WIDTH-1:0] left_word,
    input  logic signed [WORD_WIDTH-1:0] right_word,
    output logic signed [WORD_WIDTH-1:0] word
);

    logic signed [WORD_WIDTH-1:0] word_reg;
    logic signed [WORD_WIDTH-1:0] word_next;
    logic                         at_pos;
    logic                         past_pos;

    // Each cell compares its own index with the position and decides its move locally.
    assign at_pos   = (32'(ctrl.position) == 32'(INDEX));
    assign past_pos = (32'(ctrl.position) <  32'(INDEX));

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.ins)
        begin
            if (past_pos)
            begin
                word_next = left_word;
            end
            else if (at_pos)
            begin
                word_next = ins_word;
            end
        end
        else if (ctrl.del)
        begin
            if (past_pos || at_pos)
            begin
                word_next = right_word;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

/* hdl/pida_ctrl.sv */
// Request decoder: checks the position against the fill count and drives the cell commands.
`timescale 1ns / 1ps

module pida_ctrl #(
    parameter int DEPTH = pida_pkg::DEPTH_DEF
) (
    input  pida_pkg::request_t               request,
    input  logic                             accept,
    input  logic [$clog2(DEPTH+1)-1:0]       count,
    output logic [$clog2(DEPTH+1)-1:0]       count_next,
    output pida_pkg::cell_ctrl_t             cell_ctrl,
    output pida_pkg::status_t                status,
    output logic                             hit
);

    logic [31:0] pos_ext;
    logic [31:0] cnt_ext;
    logic        below_count;
    logic        full;

    assign pos_ext     = 32'(request.position);
    assign cnt_ext     = 32'(count);
    assign below_count = (pos_ext < cnt_ext);
    assign full        = (cnt_ext == 32'(DEPTH));

    always_comb
    begin
        count_next         = count;
        cell_ctrl.ins      = 1'b0;
        cell_ctrl.del      = 1'b0;
        cell_ctrl.position = request.position;
        status             = pida_pkg::ST_OK;
        hit                = 1'b0;
        unique case (request.mode)
            pida_pkg::MODE_CLEAR:
            begin
                count_next = '0;
            end
            pida_pkg::MODE_INSERT:
            begin
                // The position check comes before the full check.
                if (pos_ext > cnt_ext)
                begin
                    status = pida_pkg::ST_BADPOS;
                end
                else if (full)
                begin
                    status = pida_pkg::ST_FULL;
                end
                else
                begin
                    cell_ctrl.ins = accept;
                    count_next    = count + 1'b1;
                end
            end
            pida_pkg::MODE_DELETE:
            begin
                if (!below_count)
                begin
                    status = pida_pkg::ST_BADPOS;
                end
                else
                begin
                    cell_ctrl.del = accept;
                    count_next    = count - 1'b1;
                    hit           = 1'b1;
                end
            end
            pida_pkg::MODE_READ:
            begin
                if (!below_count)
                begin
                    status = pida_pkg::ST_BADPOS;
                end
                else
                begin
                    hit = 1'b1;
                end
            end
        endcase
    end

endmodule

/* hdl/positional_insert_delete_array_unit.sv */
// Top level of the positional insert/delete array: decoder, cell row and result register.
`timescale 1ns / 1ps

// Usage
// The block keeps an ordered list of up to DEPTH signed words and a fill count.
// A request (mode, value, position) is taken at a rising edge where start is
// high and busy is low. Clear empties the list, insert places a word at a
// position from 0 to the fill count, delete removes and returns the word at a
// position below the fill count, and read returns that word without change.
// A bad position, or an insert into a full list, changes nothing and reports
// an error status.
// Every request gives exactly one result, shown on the result port for one
// cycle with done high, in the cycle after the request was taken. The whole
// row of cells moves at the edge that takes the request, so busy never rises
// and a new request can be taken in every cycle: one request per cycle. The
// result register captures the outcome at that same edge.
// The receiver cannot stall the block; a result must be taken when shown.
// Reset clears the fill count and the done strobe. Cell contents are not
// cleared; they are only read below the fill count, so stale words never
// show up in a result.

module positional_insert_delete_array_unit #(
    parameter int DEPTH      = pida_pkg::DEPTH_DEF,
    parameter int WORD_WIDTH = pida_pkg::WORD_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  pida_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output pida_pkg::result_t  result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                         accept;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    pida_pkg::cell_ctrl_t         cell_ctrl;
    pida_pkg::status_t            status;
    logic                         hit;
    logic signed [WORD_WIDTH-1:0] ins_word;
    logic signed [WORD_WIDTH-1:0] words [DEPTH];
    logic signed [WORD_WIDTH-1:0] sel_word;
    logic                         done_reg;
    pida_pkg::result_t            result_reg;
    pida_pkg::result_t            result_next;

    // Every request is carried out at the edge where it is taken, so the block is never busy.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // The 32-bit request word is sign-extended or truncated to the storage width.
    assign ins_word = WORD_WIDTH'(request.value);

    pida_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .request    (request),
        .accept     (accept),
        .count      (count_reg),
        .count_next (count_next),
        .cell_ctrl  (cell_ctrl),
        .status     (status),
        .hit        (hit)
    );

    // Row of cells. Each one takes its left neighbor on insert and its right
    // neighbor on delete; the ends feed back their own word.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [WORD_WIDTH-1:0] left_word;
        logic signed [WORD_WIDTH-1:0] right_word;

        if (i == 0)
        begin : g_first
            assign left_word = words[i];
        end
        else
        begin : g_inner_left
            assign left_word = words[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_word = words[i];
        end
        else
        begin : g_inner_right
            assign right_word = words[i+1];
        end

        pida_cell #(
            .WORD_WIDTH (WORD_WIDTH),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .ins_word   (ins_word),
            .left_word  (left_word),
            .right_word (right_word),
            .word       (words[i])
        );
    end

    // Pick the word at the requested position for read and delete.
    always_comb
    begin
        sel_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (32'(request.position) == 32'(i))
            begin
                sel_word = words[i];
            end
        end
    end

    always_comb
    begin
        result_next.data_out   = hit ? 32'(sel_word) : 32'sd0;
        result_next.used_count = 5'(count_next);
        result_next.status     = status;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= accept;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the positional insert/delete array: directed edges, random mix.

module testbench;
    import pida_pkg::*;

    localparam int DEPTH        = DEPTH_DEF;
    // Cycles with no request taken and no result shown before the run is abandoned.
    localparam int QUIET_LIMIT  = 1000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int BURST_ITEMS  = 200;

    logic     clk;
    logic     rst_n;
    logic     start;
    request_t request;
    logic     busy;
    logic     done;
    result_t  result;

    positional_insert_delete_array_unit uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // Our own copy of the word array and its fill count, advanced once per
    // accepted request. Only words below the fill count are ever looked at.
    logic signed [31:0] shadow_words [DEPTH];
    logic        [4:0]  shadow_fill = '0;

    // Results the block still owes us, oldest first.
    result_t owed_results [$];

    int  error_count  = 0;
    bit  idle_enabled = 1'b1;
    bit  growing      = 1'b1;

    // Coverage tallies for the closing summary.
    int  n_clear      = 0;
    int  n_insert     = 0;
    int  n_delete     = 0;
    int  n_read       = 0;
    int  n_ok         = 0;
    int  n_badpos     = 0;
    int  n_full       = 0;
    int  n_on_full    = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Applies one request to the shadow array and returns the result that the
    // block must give for it. The position compare comes before the full
    // check, so an out-of-range insert into a full array reports a bad
    // position rather than a full array.
    function automatic result_t apply_request(input request_t req);
        result_t r;
        int      i;
        r.data_out = '0;
        r.status   = ST_OK;
        case (req.mode)
            MODE_CLEAR:
            begin
                // Words are left in place; only the count drops.
                shadow_fill = '0;
            end
            MODE_INSERT:
            begin
                if (req.position > shadow_fill)
                    r.status = ST_BADPOS;
                else if (shadow_fill == DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (i = shadow_fill; i > req.position; i--)
                        shadow_words[i] = shadow_words[i - 1];
                    shadow_words[req.position] = req.value;
                    shadow_fill = shadow_fill + 1'b1;
                end
            end
            MODE_DELETE:
            begin
                if (req.position >= shadow_fill)
                    r.status = ST_BADPOS;
                else
                begin
                    r.data_out = shadow_words[req.position];
                    for (i = req.position + 1; i < shadow_fill; i++)
                        shadow_words[i - 1] = shadow_words[i];
                    shadow_fill = shadow_fill - 1'b1;
                end
            end
            default:
            begin
                if (req.position >= shadow_fill)
                    r.status = ST_BADPOS;
                else
                    r.data_out = shadow_words[req.position];
            end
        endcase
        r.used_count = shadow_fill;
        return r;
    endfunction

    // Result checker and request tracker. Both sample at the rising edge, so
    // they see the values that were present when the edge arrived. The result
    // shown now belongs to a request taken at an earlier edge, so it is
    // checked before the request taken at this edge is added.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result with none expected: data_out %0d used_count %0d status %0d",
                             $time, result.data_out, result.used_count, result.status);
                    error_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (result.data_out !== want.data_out)
                    begin
                        $display("%0t: data_out mismatch, expected %0d, got %0d",
                                 $time, want.data_out, result.data_out);
                        error_count++;
                    end
                    if (result.used_count !== want.used_count)
                    begin
                        $display("%0t: used_count mismatch, expected %0d, got %0d",
                                 $time, want.used_count, result.used_count);
                        error_count++;
                    end
                    if (result.status !== want.status)
                    begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, result.status);
                        error_count++;
                    end
                    if (want.status == ST_OK)
                        n_ok++;
                    else if (want.status == ST_BADPOS)
                        n_badpos++;
                    else
                        n_full++;
                end
            end
            if (start && !busy)
            begin
                case (request.mode)
                    MODE_CLEAR:  n_clear++;
                    MODE_INSERT: n_insert++;
                    MODE_DELETE: n_delete++;
                    default:     n_read++;
                endcase
                if (shadow_fill == DEPTH)
                    n_on_full++;
                owed_results.push_back(apply_request(request));
            end
        end
    end

    // Watchdog: gives up after a long stretch in which nothing moves.
    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((rst_n && start && !busy) || done || !rst_n)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t: no progress for %0d cycles, %0d results still owed",
                 $time, QUIET_LIMIT, owed_results.size());
        $display("Some tests failed");
        $finish;
    end

    // Presents one request and returns at the edge where it was taken. Start
    // is left high so that a following request can go out in the next cycle.
    task automatic send_request(input request_t req);
        start   <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Now and then drops start for a burst whose length is drawn at random.
    task automatic maybe_idle();
        int gap;
        if (idle_enabled && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 3);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_op(input mode_t m, input logic signed [31:0] v,
                           input logic [4:0] p);
        request_t req;
        req.mode     = m;
        req.value    = v;
        req.position = p;
        send_request(req);
        maybe_idle();
    endtask

    // Holds start low until every owed result has come back. The queue is
    // looked at on the falling edge, when the checker is done with the last
    // rising edge; driving resumes on a rising edge.
    task automatic wait_for_drain();
        start <= 1'b0;
        @(negedge clk);
        while (owed_results.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Builds one random request. The mix leans toward inserts while the array
    // is filling and toward deletes while it is emptying, so that both the
    // empty and the full ends are visited often. Most positions are legal for
    // the current fill count; the rest range over all 5 bits.
    task automatic send_random_request();
        request_t   req;
        int         roll;
        logic [4:0] fill;
        fill = shadow_fill;
        if (fill == DEPTH && $urandom_range(0, 3) == 0)
            growing = 1'b0;
        if (fill == 0)
            growing = 1'b1;

        roll = $urandom_range(0, 99);
        if (roll < 2)
            req.mode = MODE_CLEAR;
        else if (roll < (growing ? 62 : 22))
            req.mode = MODE_INSERT;
        else if (roll < 82)
            req.mode = MODE_DELETE;
        else
            req.mode = MODE_READ;

        case ($urandom_range(0, 11))
            0:       req.value = 32'sh8000_0000;
            1:       req.value = 32'sh7fff_ffff;
            2:       req.value = -32'sd1;
            3:       req.value = '0;
            default: req.value = $urandom();
        endcase

        if ($urandom_range(0, 99) < 15)
            req.position = 5'($urandom_range(0, 31));
        else if (req.mode == MODE_INSERT)
            req.position = 5'($urandom_range(0, fill));
        else if (fill != 0)
            req.position = 5'($urandom_range(0, fill - 1));
        else
            req.position = 5'($urandom_range(0, 31));

        send_request(req);
        maybe_idle();
    endtask

    // Empty-array errors, the value extremes, inserts at the front, middle
    // and end, filling to the limit, inserting into a full array (both at a
    // legal position and past the end), deletes at both ends, and clear.
    task automatic test_directed_edges();
        int k;
        send_op(MODE_CLEAR, 32'sd0, 5'd0);
        send_op(MODE_READ, 32'sd0, 5'd0);
        send_op(MODE_DELETE, 32'sd0, 5'd0);
        send_op(MODE_INSERT, 32'sd5, 5'd1);
        send_op(MODE_INSERT, 32'sh8000_0000, 5'd0);
        send_op(MODE_INSERT, 32'sh7fff_ffff, 5'd1);
        send_op(MODE_INSERT, -32'sd1, 5'd0);
        send_op(MODE_INSERT, 32'sd0, 5'd1);
        send_op(MODE_READ, 32'sd0, 5'd3);
        send_op(MODE_DELETE, 32'sd0, 5'd1);
        for (k = 3; k < DEPTH; k++)
            send_op(MODE_INSERT, $urandom(), 5'($urandom_range(0, k)));
        send_op(MODE_INSERT, 32'sd7, 5'd16);
        send_op(MODE_INSERT, 32'sd7, 5'd17);
        send_op(MODE_INSERT, 32'sd7, 5'd31);
        send_op(MODE_READ, 32'sd0, 5'd16);
        send_op(MODE_DELETE, 32'sd0, 5'd15);
        send_op(MODE_DELETE, 32'sd0, 5'd0);
        send_op(MODE_CLEAR, 32'sd0, 5'd0);
    endtask

    // The sender stops until every result is back, then reads what it wrote.
    task automatic test_drain_pause();
        int k;
        for (k = 0; k < 4; k++)
            send_op(MODE_INSERT, $urandom(), 5'd0);
        wait_for_drain();
        for (k = 0; k < 4; k++)
            send_op(MODE_READ, 32'sd0, 5'(k));
    endtask

    // Long random mix with idle bursts, stretches without idling, and a
    // periodic full drain.
    task automatic test_random_mix();
        int k;
        for (k = 0; k < RANDOM_ITEMS; k++)
        begin
            idle_enabled = (k % 300) >= 60;
            send_random_request();
            if (k % 400 == 399)
                wait_for_drain();
        end
    endtask

    // Closing stretch: a request in every cycle, no idling at all.
    task automatic test_back_to_back();
        int k;
        idle_enabled = 1'b0;
        for (k = 0; k < BURST_ITEMS; k++)
            send_random_request();
    endtask

    initial
    begin
        rst_n   <= 1'b0;
        start   <= 1'b0;
        request <= '0;
        repeat (4) @(posedge clk);
        rst_n   <= 1'b1;

        test_directed_edges();
        test_drain_pause();
        test_random_mix();
        test_back_to_back();

        // Let the last results arrive, then watch a few more cycles for
        // anything stray.
        wait_for_drain();
        repeat (4) @(posedge clk);

        $display("Covered %0d requests: %0d inserts, %0d deletes, %0d reads, %0d clears.",
                 n_clear + n_insert + n_delete + n_read, n_insert, n_delete, n_read, n_clear);
        $display("Outcomes: %0d ok, %0d bad position, %0d full; %0d requests met a full array.",
                 n_ok, n_badpos, n_full, n_on_full);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
